// ===== design/gsl_pkg.sv =====
// Shared types and constants of the grammar lexer.
package gsl_pkg;

	typedef enum logic [4:0] {
		M_IDLE, M_NAME, M_NUM, M_DASH, M_SLASH, M_LCMT, M_BCMT, M_BSTAR,
		M_LITF, M_LIT, M_BLOCK, M_STR, M_DIR, M_KW, M_TOKAFT, M_SKIP,
		M_PRO, M_PROP
	} mode_t;

	localparam logic [1:0] EV_IMG = 2'd0;
	localparam logic [1:0] EV_TOK = 2'd1;
	localparam logic [1:0] EV_ERR = 2'd2;

	localparam logic [4:0] TK_EOF = 5'd0;
	localparam logic [4:0] TK_ARROW = 5'd1;
	localparam logic [4:0] TK_NEG = 5'd2;
	localparam logic [4:0] TK_LIT = 5'd3;
	localparam logic [4:0] TK_BLOCK = 5'd4;
	localparam logic [4:0] TK_OR = 5'd5;
	localparam logic [4:0] TK_EOL = 5'd6;
	localparam logic [4:0] TK_STR = 5'd7;
	localparam logic [4:0] TK_NAME = 5'd8;
	localparam logic [4:0] TK_NUM = 5'd9;
	localparam logic [4:0] TK_PRO = 5'd10;
	localparam logic [4:0] TK_SEP = 5'd11;
	localparam logic [4:0] TK_TOKEN = 5'd12;
	localparam logic [4:0] TK_PREFIX = 5'd13;
	localparam logic [4:0] TK_TEST = 5'd14;
	localparam logic [4:0] TK_TYPE = 5'd15;
	localparam logic [4:0] TK_DATATYPE = 5'd16;
	localparam logic [4:0] TK_EMPTY = 5'd17;
	localparam logic [4:0] TK_ENABLE = 5'd18;
	localparam logic [4:0] TK_LEFT = 5'd19;
	localparam logic [4:0] TK_RIGHT = 5'd20;
	localparam logic [4:0] TK_NAMESPACE = 5'd21;
	localparam logic [4:0] TK_NONASSOC = 5'd22;
	localparam logic [4:0] TK_PREC = 5'd23;

	localparam logic [2:0] ER_NONE = 3'd0;
	localparam logic [2:0] ER_CHAR = 3'd1;
	localparam logic [2:0] ER_EMPTY = 3'd2;
	localparam logic [2:0] ER_PRO = 3'd3;
	localparam logic [2:0] ER_LIT = 3'd4;
	localparam logic [2:0] ER_BLOCK = 3'd5;
	localparam logic [2:0] ER_STR = 3'd6;

	// keyword table entries
	localparam logic [3:0] KW_TOKEN = 4'd0;
	localparam logic [3:0] KW_TEST = 4'd1;
	localparam logic [3:0] KW_TYPE = 4'd2;
	localparam logic [3:0] KW_DATATYPE = 4'd3;
	localparam logic [3:0] KW_EMPTY = 4'd4;
	localparam logic [3:0] KW_ENABLE = 4'd5;
	localparam logic [3:0] KW_LEFT = 4'd6;
	localparam logic [3:0] KW_RIGHT = 4'd7;
	localparam logic [3:0] KW_NAMESPACE = 4'd8;
	localparam logic [3:0] KW_NONASSOC = 4'd9;
	localparam logic [3:0] KW_PREC = 4'd10;
	localparam logic [3:0] KW_PREFIX = 4'd11;
	localparam logic [3:0] KW_END = 4'd15;

	// keyword completion
	localparam logic [1:0] KH_EMIT = 2'd0;
	localparam logic [1:0] KH_SKIP = 2'd1;
	localparam logic [1:0] KH_WAIT = 2'd2;

	localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

	// one result item as it leaves the block
	typedef struct packed {
		logic [1:0] ev;
		logic [4:0] kind;
		logic [7:0] ch;
		logic [30:0] num;
		logic [23:0] line;
		logic [2:0] err;
		logic last;
	} res_t;

	// what the front part hands on for one request: up to two results
	typedef struct packed {
		logic two;
		res_t r0;
		res_t r1;
	} pair_t;

	function automatic logic [3:0] kw_len(input logic [3:0] g);
		case (g)
			KW_TOKEN: kw_len = 4'd4;     KW_TEST: kw_len = 4'd3;      KW_TYPE: kw_len = 4'd3;
			KW_DATATYPE: kw_len = 4'd7;  KW_EMPTY: kw_len = 4'd4;     KW_ENABLE: kw_len = 4'd9;
			KW_LEFT: kw_len = 4'd3;      KW_RIGHT: kw_len = 4'd4;     KW_NAMESPACE: kw_len = 4'd8;
			KW_NONASSOC: kw_len = 4'd7;  KW_PREC: kw_len = 4'd3;      KW_PREFIX: kw_len = 4'd6;
			default: kw_len = 4'd0;
		endcase
	endfunction

	function automatic logic [4:0] kw_kind(input logic [3:0] g);
		case (g)
			KW_TOKEN: kw_kind = TK_TOKEN;        KW_TEST: kw_kind = TK_TEST;
			KW_TYPE: kw_kind = TK_TYPE;          KW_DATATYPE: kw_kind = TK_DATATYPE;
			KW_EMPTY: kw_kind = TK_EMPTY;        KW_ENABLE: kw_kind = TK_ENABLE;
			KW_LEFT: kw_kind = TK_LEFT;          KW_RIGHT: kw_kind = TK_RIGHT;
			KW_NAMESPACE: kw_kind = TK_NAMESPACE; KW_NONASSOC: kw_kind = TK_NONASSOC;
			KW_PREC: kw_kind = TK_PREC;          KW_PREFIX: kw_kind = TK_PREFIX;
			default: kw_kind = TK_EOF;
		endcase
	endfunction

	// how: emit, swallow one byte, wait for '_'
	function automatic logic [1:0] kw_how(input logic [3:0] g);
		case (g)
			KW_TOKEN: kw_how = KH_WAIT;
			KW_TEST, KW_NAMESPACE: kw_how = KH_SKIP;
			default: kw_how = KH_EMIT;
		endcase
	endfunction

	// next alternative; KW_END means none
	function automatic logic [3:0] kw_alt(input logic [3:0] g);
		case (g)
			KW_TOKEN: kw_alt = KW_TEST; KW_TEST: kw_alt = KW_TYPE; KW_EMPTY: kw_alt = KW_ENABLE;
			KW_NAMESPACE: kw_alt = KW_NONASSOC;
			default: kw_alt = KW_END;
		endcase
	endfunction

	function automatic logic [7:0] kw_char(input logic [3:0] g, input logic [3:0] p);
		logic [71:0] s;
		case (g)
			KW_TOKEN: s = {"oken", 40'd0};
			KW_TEST: s = {"est", 48'd0};
			KW_TYPE: s = {"ype", 48'd0};
			KW_DATATYPE: s = {"atatype", 16'd0};
			KW_EMPTY: s = {"mpty", 40'd0};
			KW_ENABLE: s = {"nable", "_cst"};
			KW_LEFT: s = {"eft", 48'd0};
			KW_RIGHT: s = {"ight", 40'd0};
			KW_NAMESPACE: s = {"amespace", 8'd0};
			KW_NONASSOC: s = {"onassoc", 16'd0};
			KW_PREC: s = {"rec", 48'd0};
			KW_PREFIX: s = {"prefix", 24'd0};
			default: s = 72'd0;
		endcase
		kw_char = (p < 4'd9) ? s[8'd71 - {p, 3'b000} -: 8] : 8'd0;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		is_digit = (c >= "0") && (c <= "9");
	endfunction

	function automatic logic is_head(input logic [7:0] c);
		is_head = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
			(c == "_") || (c == "$");
	endfunction

endpackage

// ===== design/gsl_stream_if.sv =====
// Valid/ready channel with a generic payload.
interface gsl_stream_if #(parameter int W = 8);
	logic valid;
	logic ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// ===== design/grammar_spec_lexer_core.sv =====
// Channel   Dir  Payload
// in        in   character[7:0], end_of_file
// out       out  event_kind, token_kind, image_char, number_value, token_line,
//                error_code, last_of_run
// One byte accepted per cycle; a byte's one or two results leave one per cycle
// from a two-entry queue while the output is ready.
// The front state register update is the limiting loop.
// Reset clears lexer state and the queue; no clearing pass.
// Input stalls only when the queue is full and the front register holds.
module grammar_spec_lexer_core import gsl_pkg::*; #(
	parameter int MAX_NESTING = 255,
	parameter int NUMBER_BITS = 31
) (
	input logic clk,
	input logic arst_n,
	gsl_stream_if.sink in_ch,
	gsl_stream_if.source out_ch
);
	logic p_valid, p_ready;
	pair_t p_data;
	res_t o_data;
	logic [$bits(in_ch.data)-1:0] in_d;

	assign in_d = in_ch.data;

	gsl_front #(.MAX_NESTING(MAX_NESTING), .NUMBER_BITS(NUMBER_BITS)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_char(in_d[8:1]), .in_eof(in_d[0]),
		.in_ready(in_ch.ready),
		.p_valid(p_valid), .p_data(p_data), .p_ready(p_ready)
	);

	gsl_back u_back (
		.clk(clk), .arst_n(arst_n),
		.p_valid(p_valid), .p_data(p_data), .p_ready(p_ready),
		.o_valid(out_ch.valid), .o_data(o_data), .o_ready(out_ch.ready)
	);

	assign out_ch.data = {o_data.ev, o_data.kind, o_data.ch, o_data.num, o_data.line,
		o_data.err, o_data.last};

`ifndef SYNTHESIS
	a_err_no_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && o_data.ev == EV_ERR |-> o_data.kind == TK_EOF && o_data.err != ER_NONE)
		else $error("error result with kind or no code");
	a_tok_no_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && o_data.ev == EV_TOK |-> o_data.ch == 8'd0)
		else $error("token result carries a character");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid)
		else $error("result dropped under stall");
`endif
endmodule

// ===== design/gsl_front.sv =====
// Lexer state machine: classifies each byte and builds its result pair.
module gsl_front import gsl_pkg::*; #(
	parameter int MAX_NESTING = 255,
	parameter int NUMBER_BITS = 31
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_char,
	input logic in_eof,
	output logic in_ready,
	output logic p_valid,
	output pair_t p_data,
	input logic p_ready
);
	localparam int DW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING + 1) : 1;
	localparam logic [DW-1:0] DMAX = DW'(MAX_NESTING);
	localparam logic [NUMBER_BITS-1:0] NMAX = {NUMBER_BITS{1'b1}};
	localparam logic [NUMBER_BITS-1:0] NLIM = NMAX / 10;
	localparam logic [3:0] NLIMR = 4'(NMAX % 10);

	mode_t mode_q, mode_d;
	logic [3:0] kpos_q, kpos_d;
	logic [4:0] guess_q, guess_d;
	logic [DW-1:0] depth_q, depth_d;
	logic [23:0] line_q, line_d;
	logic [NUMBER_BITS-1:0] acc_q, acc_d;
	logic [23:0] start_q, start_d;

	logic [1:0] n;
	res_t r [2];
	logic take;

	assign in_ready = p_ready;
	assign take = in_valid && in_ready;

	function automatic logic [23:0] bump(input logic [23:0] l);
		bump = (l < LINE_MAX) ? l + 24'd1 : l;
	endfunction

	function automatic res_t mk(input logic [1:0] ev, input logic [4:0] k,
			input logic [7:0] c, input logic [30:0] v, input logic [23:0] l,
			input logic [2:0] e);
		res_t x;
		x.ev = ev; x.kind = k; x.ch = c; x.num = v; x.line = l; x.err = e;
		x.last = 1'b0;
		mk = x;
	endfunction

	always_comb begin
		logic [7:0] c;
		logic [3:0] g0, g1, g2;
		logic [3:0] p;
		logic [3:0] dg;
		logic hit;
		logic fallback;
		c = in_char;
		mode_d = mode_q; kpos_d = kpos_q; guess_d = guess_q; depth_d = depth_q;
		line_d = line_q; acc_d = acc_q; start_d = start_q;
		n = 2'd0;
		r[0] = '0; r[1] = '0;
		fallback = 1'b0;
		g0 = 4'd0; g1 = 4'd0; g2 = 4'd0; p = 4'd0; hit = 1'b0;
		dg = 4'(c - "0");
		if (in_eof) begin
			mode_d = M_IDLE;
			unique case (mode_q)
				M_NAME, M_NUM, M_DASH, M_TOKAFT, M_SKIP: begin
					r[0] = mk(EV_TOK, (mode_q == M_NAME) ? TK_NAME :
						(mode_q == M_NUM) ? TK_NUM : (mode_q == M_DASH) ? TK_NEG :
						(mode_q == M_TOKAFT) ? TK_TOKEN : guess_q,
						8'd0, (mode_q == M_NUM) ? 31'(acc_q) : 31'd0, start_q, ER_NONE);
					r[1] = mk(EV_TOK, TK_EOF, 8'd0, 31'd0, line_q, ER_NONE);
					n = 2'd2;
				end
				M_SLASH, M_BCMT, M_BSTAR, M_DIR, M_KW: begin
					r[0] = mk(EV_ERR, TK_EOF, 8'd0, 31'd0, line_q, ER_CHAR); n = 2'd1;
				end
				M_LITF, M_LIT: begin
					r[0] = mk(EV_ERR, TK_EOF, 8'd0, 31'd0, line_q, ER_LIT); n = 2'd1;
				end
				M_BLOCK: begin
					r[0] = mk(EV_ERR, TK_EOF, 8'd0, 31'd0, line_q, ER_BLOCK); n = 2'd1;
				end
				M_STR: begin
					r[0] = mk(EV_ERR, TK_EOF, 8'd0, 31'd0, line_q, ER_STR); n = 2'd1;
				end
				M_PRO, M_PROP: begin
					r[0] = mk(EV_ERR, TK_EOF, 8'd0, 31'd0, line_q, ER_PRO); n = 2'd1;
				end
				default: begin
					r[0] = mk(EV_TOK, TK_EOF, 8'd0, 31'd0, line_q, ER_NONE); n = 2'd1;
				end
			endcase
		end else begin
			unique case (mode_q)
				M_NAME: begin
					if (is_head(c) || is_digit(c)) begin
						r[0] = mk(EV_IMG, TK_NAME, c, 31'd0, start_q, ER_NONE); n = 2'd1;
					end else begin
						r[0] = mk(EV_TOK, TK_NAME, 8'd0, 31'd0, start_q, ER_NONE); n = 2'd1;
						fallback = 1'b1;
					end
				end
				M_NUM: begin
					if (is_digit(c)) begin
						if (acc_q > NLIM || (acc_q == NLIM && dg > NLIMR)) acc_d = NMAX;
						else acc_d = NUMBER_BITS'(acc_q * 10) + NUMBER_BITS'(dg);
					end else begin
						r[0] = mk(EV_TOK, TK_NUM, 8'd0, 31'(acc_q), start_q, ER_NONE);
						n = 2'd1; fallback = 1'b1;
					end
				end
				M_DASH: begin
					if (c == ">") begin
						r[0] = mk(EV_TOK, TK_ARROW, 8'd0, 31'd0, start_q, ER_NONE);
						n = 2'd1; mode_d = M_IDLE;
					end else begin
						r[0] = mk(EV_TOK, TK_NEG, 8'd0, 31'd0, start_q, ER_NONE);
						n = 2'd1; fallback = 1'b1;
					end
				end
				M_SLASH: begin
					if (c == "/") mode_d = M_LCMT;
					else if (c == "*") mode_d = M_BCMT;
					else begin
						r[0] = mk(EV_ERR, TK_EOF, c, 31'd0, line_q, ER_CHAR);
						n = 2'd1; mode_d = M_IDLE;
					end
				end
				M_LCMT: begin
					if (c == "\n") begin line_d = bump(line_q); mode_d = M_IDLE; end
				end
				M_BCMT: begin
					if (c == "*") mode_d = M_BSTAR;
					else if (c == "\n") line_d = bump(line_q);
				end
				M_BSTAR: begin
					if (c == "/") mode_d = M_IDLE;
					else if (c == "\n") begin
						line_d = bump(bump(line_q)); mode_d = M_BCMT;
					end else if (c != "*") mode_d = M_BCMT;
				end
				M_LITF: begin
					if (c == ">") begin
						r[0] = mk(EV_ERR, TK_EOF, c, 31'd0, line_q, ER_EMPTY);
						n = 2'd1; mode_d = M_IDLE;
					end else begin
						r[0] = mk(EV_IMG, TK_LIT, c, 31'd0, start_q, ER_NONE);
						n = 2'd1; mode_d = M_LIT;
					end
				end
				M_LIT: begin
					n = 2'd1;
					if (c == ">") begin
						r[0] = mk(EV_TOK, TK_LIT, 8'd0, 31'd0, start_q, ER_NONE);
						mode_d = M_IDLE;
					end else r[0] = mk(EV_IMG, TK_LIT, c, 31'd0, start_q, ER_NONE);
				end
				M_BLOCK: begin
					n = 2'd1;
					r[0] = mk(EV_IMG, TK_BLOCK, c, 31'd0, start_q, ER_NONE);
					if (c == "}") begin
						if (depth_q <= DW'(1)) begin
							depth_d = '0; mode_d = M_IDLE;
							r[0] = mk(EV_TOK, TK_BLOCK, 8'd0, 31'd0, start_q, ER_NONE);
						end else depth_d = depth_q - DW'(1);
					end else if (c == "{") begin
						if (depth_q < DMAX) depth_d = depth_q + DW'(1);
					end else if (c == "\n") line_d = bump(line_q);
				end
				M_STR: begin
					n = 2'd1;
					if (c == "\"") begin
						r[0] = mk(EV_TOK, TK_STR, 8'd0, 31'd0, start_q, ER_NONE);
						mode_d = M_IDLE;
					end else begin
						if (c == "\n") line_d = bump(line_q);
						r[0] = mk(EV_IMG, TK_STR, c, 31'd0, start_q, ER_NONE);
					end
				end
				M_DIR: begin
					mode_d = M_KW; kpos_d = 4'd0;
					case (c)
						"t": guess_d = {1'b0, KW_TOKEN};
						"d": guess_d = {1'b0, KW_DATATYPE};
						"e": guess_d = {1'b0, KW_EMPTY};
						"l": guess_d = {1'b0, KW_LEFT};
						"r": guess_d = {1'b0, KW_RIGHT};
						"n": guess_d = {1'b0, KW_NAMESPACE};
						"p": guess_d = {1'b0, KW_PREC};
						"%": begin
							mode_d = M_IDLE; n = 2'd1;
							r[0] = mk(EV_TOK, TK_SEP, 8'd0, 31'd0, start_q, ER_NONE);
						end
						"{": mode_d = M_PRO;
						default: begin
							mode_d = M_IDLE; n = 2'd1;
							r[0] = mk(EV_ERR, TK_EOF, c, 31'd0, line_q, ER_CHAR);
						end
					endcase
				end
				M_KW: begin
					// try the guess and up to two alternatives for this byte
					g0 = guess_q[3:0]; g1 = kw_alt(g0);
					g2 = (g1 == KW_END) ? KW_END : kw_alt(g1);
					if (guess_q > {1'b0, KW_PREFIX}) hit = 1'b0;
					else if (kpos_q < kw_len(g0) && kw_char(g0, kpos_q) == c) begin
						hit = 1'b1; p = kpos_q;
					end else if (g1 != KW_END && kw_char(g1, 4'd0) == c) begin
						hit = 1'b1; p = 4'd0; g0 = g1;
					end else if (g1 != KW_END && g2 != KW_END && kw_char(g2, 4'd0) == c) begin
						hit = 1'b1; p = 4'd0; g0 = g2;
					end
					if (!hit) begin
						mode_d = M_IDLE; n = 2'd1;
						r[0] = mk(EV_ERR, TK_EOF, c, 31'd0, line_q, ER_CHAR);
					end else begin
						guess_d = {1'b0, g0}; kpos_d = p + 4'd1;
						if (p + 4'd1 >= kw_len(g0)) begin
							case (kw_how(g0))
								KH_EMIT: begin
									mode_d = M_IDLE; n = 2'd1;
									r[0] = mk(EV_TOK, kw_kind(g0), 8'd0, 31'd0, start_q, ER_NONE);
								end
								KH_SKIP: begin guess_d = kw_kind(g0); mode_d = M_SKIP; end
								default: mode_d = M_TOKAFT;
							endcase
						end
					end
				end
				M_TOKAFT: begin
					if (c == "_") begin
						guess_d = {1'b0, KW_PREFIX}; kpos_d = 4'd0; mode_d = M_KW;
					end else begin
						r[0] = mk(EV_TOK, TK_TOKEN, 8'd0, 31'd0, start_q, ER_NONE);
						n = 2'd1; fallback = 1'b1;
					end
				end
				M_SKIP: begin
					r[0] = mk(EV_TOK, guess_q, 8'd0, 31'd0, start_q, ER_NONE);
					n = 2'd1; mode_d = M_IDLE;
				end
				M_PRO: begin
					if (c == "%") mode_d = M_PROP;
					else begin
						if (c == "\n") line_d = bump(line_q);
						r[0] = mk(EV_IMG, TK_PRO, c, 31'd0, start_q, ER_NONE); n = 2'd1;
					end
				end
				M_PROP: begin
					if (c == "}") begin
						r[0] = mk(EV_TOK, TK_PRO, 8'd0, 31'd0, start_q, ER_NONE);
						n = 2'd1; mode_d = M_IDLE;
					end else begin
						r[0] = mk(EV_IMG, TK_PRO, "%", 31'd0, start_q, ER_NONE);
						r[1] = mk(EV_IMG, TK_PRO, c, 31'd0, start_q, ER_NONE);
						n = 2'd2; mode_d = M_PRO;
					end
				end
				default: fallback = 1'b1;
			endcase
			if (fallback) begin
				// reprocess the lookahead byte from idle
				mode_d = M_IDLE;
				if (c == " " || c == "\t") begin
				end else if (c == "\n") line_d = bump(line_q);
				else begin
					start_d = line_q;
					case (c)
						"%": mode_d = M_DIR;
						":": begin r[n[0]] = mk(EV_TOK, TK_ARROW, 8'd0, 31'd0, line_q,
							ER_NONE); n = n + 2'd1; end
						"-": mode_d = M_DASH;
						"<": mode_d = M_LITF;
						"{": begin depth_d = DW'(1); mode_d = M_BLOCK; end
						"|": begin r[n[0]] = mk(EV_TOK, TK_OR, 8'd0, 31'd0, line_q,
							ER_NONE); n = n + 2'd1; end
						";": begin r[n[0]] = mk(EV_TOK, TK_EOL, 8'd0, 31'd0, line_q,
							ER_NONE); n = n + 2'd1; end
						"\"": mode_d = M_STR;
						"/": mode_d = M_SLASH;
						default: begin
							if (is_head(c)) begin
								r[n[0]] = mk(EV_IMG, TK_NAME, c, 31'd0, line_q, ER_NONE);
								n = n + 2'd1; mode_d = M_NAME;
							end else if (is_digit(c)) begin
								acc_d = NUMBER_BITS'(dg); mode_d = M_NUM;
							end else begin
								r[n[0]] = mk(EV_ERR, TK_EOF, c, 31'd0, line_q, ER_CHAR);
								n = n + 2'd1;
							end
						end
					endcase
				end
			end
		end
		if (n == 2'd2) r[1].last = 1'b1;
		else r[0].last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE; kpos_q <= '0; guess_q <= '0; depth_q <= '0;
			line_q <= 24'd1; acc_q <= '0; start_q <= 24'd1;
			p_valid <= 1'b0;
		end else begin
			if (p_ready) p_valid <= take && (n != 2'd0);
			if (take) begin
				mode_q <= mode_d; kpos_q <= kpos_d; guess_q <= guess_d;
				depth_q <= depth_d; line_q <= line_d; acc_q <= acc_d; start_q <= start_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			p_data.two <= (n == 2'd2);
			p_data.r0 <= r[0];
			p_data.r1 <= r[1];
		end
	end
endmodule

// ===== design/gsl_back.sv =====
// Output side: two-entry pair queue that issues one result a cycle while the output is ready.
module gsl_back import gsl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic p_valid,
	input pair_t p_data,
	output logic p_ready,
	output logic o_valid,
	output res_t o_data,
	input logic o_ready
);
	pair_t q_q [2];
	logic [1:0] cnt_q;
	logic rd_q, wr_q;
	logic half_q;
	logic pop, push;

	assign o_valid = cnt_q != 2'd0;
	assign o_data = half_q ? q_q[rd_q].r1 : q_q[rd_q].r0;
	// the front holds its register until we have room
	assign p_ready = (cnt_q != 2'd2) || pop;
	assign pop = o_valid && o_ready && (half_q || !q_q[rd_q].two);
	assign push = p_valid && p_ready && (cnt_q != 2'd2 || pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0; rd_q <= 1'b0; wr_q <= 1'b0; half_q <= 1'b0;
		end else begin
			if (o_valid && o_ready) begin
				if (pop) begin half_q <= 1'b0; rd_q <= ~rd_q; end
				else half_q <= 1'b1;
			end
			if (push) wr_q <= ~wr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) q_q[wr_q] <= p_data;
	end
endmodule
